### design/alux_pkg.sv
package alux_pkg;

  // fixed widths of the channel fields
  localparam int CNT_W    = 16;
  localparam int CODE_W   = 3;
  localparam int GLASS_W  = 12;
  localparam int LUX_W    = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  // gain times integration time fits 16 bits (96 * 400)
  localparam int GT_W   = 16;
  localparam int MULT_W = 7;
  localparam int MS_W   = 9;

  localparam int COEFF_FRAC_BITS_DEF = 12;
  localparam int LUX_FRAC_BITS_DEF   = 8;

  localparam logic [CNT_W-1:0] LOW_LIMIT  = 16'd2000;
  localparam logic [CNT_W-1:0] HIGH_LIMIT = 16'd50000;
  localparam logic [CNT_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [GLASS_W-1:0] GLASS_RESET = 12'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLASS      = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SAT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DARK  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RATIO = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZGAIN = 3'd4;

  // ratio regions of the piecewise fit
  localparam logic [1:0] RG_LOW  = 2'd0;
  localparam logic [1:0] RG_MID  = 2'd1;
  localparam logic [1:0] RG_HIGH = 2'd2;
  localparam logic [1:0] RG_OUT  = 2'd3;

  typedef struct packed {
    logic              adjust;
    logic [CODE_W-1:0] gain;
    logic [CODE_W-1:0] itime;
  } range_t;

  typedef struct packed {
    logic             done;
    logic             sat;
    logic [LUX_W-1:0] quot;
  } div_res_t;

  // coefficient in ten-thousandths, rounded to nearest at cbits fraction bits
  function automatic longint fixc(input longint k, input int cbits);
    return ((k << cbits) + 64'd5000) / 64'd10000;
  endfunction

  function automatic logic [MULT_W-1:0] gain_mult(input logic [CODE_W-1:0] code);
    logic [MULT_W-1:0] m;
    unique case (code)
      3'd0: m = 7'd1;
      3'd1: m = 7'd2;
      3'd2: m = 7'd4;
      3'd3: m = 7'd8;
      3'd6: m = 7'd48;
      3'd7: m = 7'd96;
      default: m = 7'd0;
    endcase
    return m;
  endfunction

  function automatic logic [MS_W-1:0] time_ms(input logic [CODE_W-1:0] code);
    logic [MS_W-1:0] t;
    unique case (code)
      3'd0: t = 9'd100;
      3'd1: t = 9'd50;
      3'd2: t = 9'd200;
      3'd3: t = 9'd400;
      3'd4: t = 9'd150;
      3'd5: t = 9'd250;
      3'd6: t = 9'd300;
      default: t = 9'd350;
    endcase
    return t;
  endfunction

  // gain ladder 0,1,2,3,6,7; codes 4 and 5 are off the ladder and stay put
  function automatic logic [CODE_W-1:0] gain_step(input logic [CODE_W-1:0] code,
                                                  input logic up);
    logic [CODE_W-1:0] n;
    unique case (code)
      3'd0: n = up ? 3'd1 : 3'd0;
      3'd1: n = up ? 3'd2 : 3'd0;
      3'd2: n = up ? 3'd3 : 3'd1;
      3'd3: n = up ? 3'd6 : 3'd2;
      3'd6: n = up ? 3'd7 : 3'd3;
      3'd7: n = up ? 3'd7 : 3'd6;
      default: n = code;
    endcase
    return n;
  endfunction

  // time ladder 1,0,4,2,5,6,7,3 (50 ms up to 400 ms)
  function automatic logic [CODE_W-1:0] time_step(input logic [CODE_W-1:0] code,
                                                  input logic up);
    logic [CODE_W-1:0] n;
    unique case (code)
      3'd1: n = up ? 3'd0 : 3'd1;
      3'd0: n = up ? 3'd4 : 3'd1;
      3'd4: n = up ? 3'd2 : 3'd0;
      3'd2: n = up ? 3'd5 : 3'd4;
      3'd5: n = up ? 3'd6 : 3'd2;
      3'd6: n = up ? 3'd7 : 3'd5;
      3'd7: n = up ? 3'd3 : 3'd6;
      default: n = up ? 3'd3 : 3'd7;
    endcase
    return n;
  endfunction

endpackage

### design/ambient_light_autorange_lux.sv
// channel   direction  handshake               payload
// in_       request    in_valid / in_stall     new_collection, visible_count, infrared_count
// out_      result     out_valid / out_stall   adjust, gain/time codes, lux, status, counts
// cfg_      write      cfg_we                  cfg_index, cfg_wdata
//
// A request with lux goes through classify, the shared multiplier steps, divider load, the
// serial divider (32 quotient bits, then done), output and back to idle; a quotient too big
// for 32 bits skips the serial steps. adjust or non-ok status goes from classify to output.
// in_stall is high from acceptance until the result enters the output register;
// the output register holds a result under out_stall while a new request is taken.
// rst_n is synchronous; codes reset to 0 and glass_factor to 1.0.
module ambient_light_autorange_lux #(
  parameter int COEFF_FRAC_BITS = alux_pkg::COEFF_FRAC_BITS_DEF,
  parameter int LUX_FRAC_BITS   = alux_pkg::LUX_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_new_collection,
  input  logic [alux_pkg::CNT_W-1:0]    in_visible_count,
  input  logic [alux_pkg::CNT_W-1:0]    in_infrared_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_adjust,
  output logic [alux_pkg::CODE_W-1:0]   out_gain_code,
  output logic [alux_pkg::CODE_W-1:0]   out_time_code,
  output logic [alux_pkg::LUX_W-1:0]    out_lux_value,
  output logic [alux_pkg::STATUS_W-1:0] out_status,
  output logic [alux_pkg::CNT_W-1:0]    out_visible_out,
  output logic [alux_pkg::CNT_W-1:0]    out_infrared_out,
  input  logic                          cfg_we,
  input  logic [alux_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [alux_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int CW   = COEFF_FRAC_BITS + 3;
  localparam int SUMW = COEFF_FRAC_BITS + 19;
  localparam int NUMW = SUMW + 19;
  localparam int PW   = SUMW + alux_pkg::CNT_W;
  localparam int SH   = COEFF_FRAC_BITS + 8 - LUX_FRAC_BITS;
  localparam int DIVW = alux_pkg::LUX_W + alux_pkg::GT_W;
  localparam int RW   = alux_pkg::CNT_W + 8;

  localparam logic [CW-1:0] CL0 = CW'(alux_pkg::fixc(17743, COEFF_FRAC_BITS));
  localparam logic [CW-1:0] CL1 = CW'(alux_pkg::fixc(11059, COEFF_FRAC_BITS));
  localparam logic [CW-1:0] CM0 = CW'(alux_pkg::fixc(42785, COEFF_FRAC_BITS));
  localparam logic [CW-1:0] CM1 = CW'(alux_pkg::fixc(19548, COEFF_FRAC_BITS));
  localparam logic [CW-1:0] CH0 = CW'(alux_pkg::fixc(5926, COEFF_FRAC_BITS));
  localparam logic [CW-1:0] CH1 = CW'(alux_pkg::fixc(1185, COEFF_FRAC_BITS));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLASS = 4'd1;
  localparam logic [3:0] S_M0    = 4'd2;
  localparam logic [3:0] S_M1    = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_M2    = 4'd5;
  localparam logic [3:0] S_M3    = 4'd6;
  localparam logic [3:0] S_DLOAD = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  // configuration
  logic                          auto_r;
  logic [alux_pkg::CODE_W-1:0]   sgain_r;
  logic [alux_pkg::CODE_W-1:0]   stime_r;
  logic [alux_pkg::GLASS_W-1:0]  glass_r;

  logic [3:0]                    state_r, state_nxt;
  logic [alux_pkg::CNT_W-1:0]    ch0_r, ch1_r;
  logic [1:0]                    region_r, region_nxt;
  logic [alux_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [alux_pkg::LUX_W-1:0]    lux_r, lux_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;
  logic [NUMW-1:0]               acc_r, acc_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          oadj_r;
  logic [alux_pkg::CODE_W-1:0]   ogain_r, otime_r;
  logic [alux_pkg::LUX_W-1:0]    olux_r;
  logic [alux_pkg::STATUS_W-1:0] ostat_r;
  logic [alux_pkg::CNT_W-1:0]    ovis_r, oir_r;

  logic                          accept;
  logic                          out_free;
  alux_pkg::range_t              range;
  alux_pkg::div_res_t            div_res;
  logic                          div_start;

  logic [SUMW-1:0]               mul_a;
  logic [alux_pkg::CNT_W-1:0]    mul_b;
  logic [alux_pkg::CNT_W:0]      tot;
  logic [RW-1:0]                 ir100, t45, t64, t85;
  logic [CW-1:0]                 c0, c1;
  logic [NUMW-1:0]               term_b;
  logic [NUMW:0]                 dsum, dsh;
  logic [DIVW-1:0]               dividend;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r  <= 1'b0;
      sgain_r <= '0;
      stime_r <= '0;
      glass_r <= alux_pkg::GLASS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        alux_pkg::CFG_AUTO:       auto_r  <= cfg_wdata[0];
        alux_pkg::CFG_START_GAIN: sgain_r <= cfg_wdata[alux_pkg::CODE_W-1:0];
        alux_pkg::CFG_START_TIME: stime_r <= cfg_wdata[alux_pkg::CODE_W-1:0];
        alux_pkg::CFG_GLASS:      glass_r <= cfg_wdata[alux_pkg::GLASS_W-1:0];
        default: ;
      endcase
    end
  end

  alux_range u_range (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .new_collection (in_new_collection),
    .visible        (in_visible_count),
    .auto_en        (auto_r),
    .start_gain     (sgain_r),
    .start_time     (stime_r),
    .range          (range)
  );

  alux_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (prod_r[alux_pkg::GT_W-1:0]),
    .res      (div_res)
  );

  // ratio tests by cross-multiplication: 100*ch1 against k*(ch0+ch1)
  always_comb begin
    tot   = {1'b0, ch0_r} + {1'b0, ch1_r};
    ir100 = RW'(ch1_r) * RW'(100);
    t45   = RW'(tot) * RW'(45);
    t64   = RW'(tot) * RW'(64);
    t85   = RW'(tot) * RW'(85);
  end

  always_comb begin
    unique case (region_r)
      alux_pkg::RG_LOW: begin
        c0 = CL0;
        c1 = CL1;
      end
      alux_pkg::RG_MID: begin
        c0 = CM0;
        c1 = CM1;
      end
      default: begin
        c0 = CH0;
        c1 = CH1;
      end
    endcase
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_M0: begin
        mul_a = SUMW'(c0);
        mul_b = ch0_r;
      end
      S_M1: begin
        mul_a = SUMW'(c1);
        mul_b = ch1_r;
      end
      S_M2: begin
        mul_a = acc_r[SUMW-1:0];
        mul_b = alux_pkg::CNT_W'(glass_r);
      end
      S_M3: begin
        mul_a = SUMW'(alux_pkg::gain_mult(range.gain));
        mul_b = alux_pkg::CNT_W'(alux_pkg::time_ms(range.itime));
      end
      default: ;
    endcase
  end

  // rounding: floor((num + den/2) / den) with den = gt << SH
  always_comb begin
    term_b   = NUMW'(prod_r);
    dsum     = (NUMW+1)'(acc_r) + ((NUMW+1)'(prod_r[alux_pkg::GT_W-1:0]) << (SH - 1));
    dsh      = dsum >> SH;
    dividend = DIVW'(dsh);
  end

  always_comb begin
    state_nxt  = state_r;
    region_nxt = region_r;
    status_nxt = status_r;
    lux_nxt    = lux_r;
    prod_nxt   = PW'(mul_a) * PW'(mul_b);
    acc_nxt    = acc_r;
    div_start  = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        lux_nxt = '0;
        if (ir100 < t45)      region_nxt = alux_pkg::RG_LOW;
        else if (ir100 < t64) region_nxt = alux_pkg::RG_MID;
        else if (ir100 < t85) region_nxt = alux_pkg::RG_HIGH;
        else                  region_nxt = alux_pkg::RG_OUT;
        priority if (range.adjust)
          status_nxt = alux_pkg::ST_OK;
        else if (ch0_r == alux_pkg::FULL_SCALE || ch1_r == alux_pkg::FULL_SCALE)
          status_nxt = alux_pkg::ST_SAT;
        else if (ch0_r == '0 && ch1_r == '0)
          status_nxt = alux_pkg::ST_DARK;
        else if (!(ir100 < t85))
          status_nxt = alux_pkg::ST_RATIO;
        else if (alux_pkg::gain_mult(range.gain) == '0)
          status_nxt = alux_pkg::ST_ZGAIN;
        else
          status_nxt = alux_pkg::ST_OK;
        if (range.adjust || status_nxt != alux_pkg::ST_OK) state_nxt = S_OUT;
        else                                                state_nxt = S_M0;
      end
      S_M0: state_nxt = S_M1;
      S_M1: begin
        acc_nxt   = NUMW'(prod_r);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (region_r == alux_pkg::RG_MID)
          acc_nxt = (acc_r > term_b) ? acc_r - term_b : '0;
        else
          acc_nxt = acc_r + term_b;
        state_nxt = S_M2;
      end
      S_M2: state_nxt = S_M3;
      S_M3: begin
        // times 100 as shift-adds
        acc_nxt   = (NUMW'(prod_r) << 6) + (NUMW'(prod_r) << 5) + (NUMW'(prod_r) << 2);
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          lux_nxt   = div_res.sat ? '1 : div_res.quot;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    region_r <= region_nxt;
    status_r <= status_nxt;
    lux_r    <= lux_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    if (accept) begin
      ch0_r <= in_visible_count;
      ch1_r <= in_infrared_count;
    end
    if (state_r == S_OUT && out_free) begin
      oadj_r  <= range.adjust;
      ogain_r <= range.gain;
      otime_r <= range.itime;
      olux_r  <= lux_r;
      ostat_r <= status_r;
      ovis_r  <= ch0_r;
      oir_r   <= ch1_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_adjust       = oadj_r;
  assign out_gain_code    = ogain_r;
  assign out_time_code    = otime_r;
  assign out_lux_value    = olux_r;
  assign out_status       = ostat_r;
  assign out_visible_out  = ovis_r;
  assign out_infrared_out = oir_r;

endmodule

### design/alux_range.sv
module alux_range (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic                        new_collection,
  input  logic [alux_pkg::CNT_W-1:0]  visible,
  input  logic                        auto_en,
  input  logic [alux_pkg::CODE_W-1:0] start_gain,
  input  logic [alux_pkg::CODE_W-1:0] start_time,
  output alux_pkg::range_t            range
);

  logic [alux_pkg::CODE_W-1:0] gain_r, gain_nxt;
  logic [alux_pkg::CODE_W-1:0] time_r, time_nxt;
  logic                        adj_r, adj_nxt;
  logic [alux_pkg::CODE_W-1:0] g0, t0, gs, ts;
  logic                        dim, bright;

  always_comb begin
    g0     = new_collection ? start_gain : gain_r;
    t0     = new_collection ? start_time : time_r;
    dim    = (visible <= alux_pkg::LOW_LIMIT);
    bright = (visible >= alux_pkg::HIGH_LIMIT);
    gs     = alux_pkg::gain_step(g0, dim);
    ts     = alux_pkg::time_step(t0, dim);
    gain_nxt = gain_r;
    time_nxt = time_r;
    adj_nxt  = adj_r;
    if (load) begin
      gain_nxt = g0;
      time_nxt = t0;
      adj_nxt  = 1'b0;
      // gain moves first, time only once gain has no room
      if (auto_en && (dim || bright)) begin
        if (gs != g0) begin
          gain_nxt = gs;
          adj_nxt  = 1'b1;
        end else if (ts != t0) begin
          time_nxt = ts;
          adj_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
      time_r <= '0;
      adj_r  <= 1'b0;
    end else begin
      gain_r <= gain_nxt;
      time_r <= time_nxt;
      adj_r  <= adj_nxt;
    end
  end

  assign range.adjust = adj_r;
  assign range.gain   = gain_r;
  assign range.itime  = time_r;

endmodule

### design/alux_div.sv
module alux_div (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  input  logic [alux_pkg::LUX_W+alux_pkg::GT_W-1:0]   dividend,
  input  logic [alux_pkg::GT_W-1:0]                   divisor,
  output alux_pkg::div_res_t                          res
);

  localparam int QW  = alux_pkg::LUX_W;
  localparam int GW  = alux_pkg::GT_W;
  localparam int CNW = $clog2(QW);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           sat_r, sat_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [GW-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]  num_r, num_nxt;
  logic [GW-1:0]  dvs_r, dvs_nxt;
  logic [GW:0]    trial;
  logic           fits;

  always_comb begin
    trial    = {rem_r, num_r[QW-1]};
    fits     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      dvs_nxt = divisor;
      rem_nxt = dividend[QW+GW-1:QW];
      num_nxt = dividend[QW-1:0];
      cnt_nxt = '0;
      // quotient would not fit 32 bits
      if (dividend[QW+GW-1:QW] >= divisor) begin
        sat_nxt  = 1'b1;
        done_nxt = 1'b1;
      end else begin
        sat_nxt  = 1'b0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? GW'(trial - {1'b0, dvs_r}) : trial[GW-1:0];
      num_nxt = {num_r[QW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= sat_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.sat  = sat_r;
  assign res.quot = num_r;

endmodule

### verif/alux_checker.sv
`timescale 1ns / 100ps
module alux_checker import alux_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_new_collection,
  input  logic [CNT_W-1:0]     in_visible_count,
  input  logic [CNT_W-1:0]     in_infrared_count,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_adjust,
  input  logic [CODE_W-1:0]    out_gain_code,
  input  logic [CODE_W-1:0]    out_time_code,
  input  logic [LUX_W-1:0]     out_lux_value,
  input  logic [STATUS_W-1:0]  out_status,
  input  logic [CNT_W-1:0]     out_visible_out,
  input  logic [CNT_W-1:0]     out_infrared_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   errors,
  output int                   pending,
  output int                   n_checked,
  output int                   n_adjust,
  output int                   n_lux
);

  localparam int COEF_FRAC  = COEFF_FRAC_BITS_DEF;
  localparam int LUX_FRAC   = LUX_FRAC_BITS_DEF;
  localparam int GLASS_FRAC = 8;

  // ladders listed from least to most sensitive, three bits per rung
  localparam logic [17:0] GAIN_RUNGS = {3'd7, 3'd6, 3'd3, 3'd2, 3'd1, 3'd0};
  localparam logic [23:0] TIME_RUNGS = {3'd3, 3'd7, 3'd6, 3'd5, 3'd2, 3'd4, 3'd0, 3'd1};

  // lookups indexed by code
  localparam logic [55:0] GAIN_FACTORS =
    {7'd96, 7'd48, 7'd0, 7'd0, 7'd8, 7'd4, 7'd2, 7'd1};
  localparam logic [71:0] PERIOD_MS =
    {9'd350, 9'd300, 9'd250, 9'd150, 9'd400, 9'd200, 9'd50, 9'd100};

  function automatic longint unsigned to_fixed(input longint unsigned ten_thousandths);
    return ((ten_thousandths << COEF_FRAC) + 64'd5000) / 64'd10000;
  endfunction

  localparam longint unsigned K_LO_VIS  = to_fixed(17743);
  localparam longint unsigned K_LO_IR   = to_fixed(11059);
  localparam longint unsigned K_MID_VIS = to_fixed(42785);
  localparam longint unsigned K_MID_IR  = to_fixed(19548);
  localparam longint unsigned K_HI_VIS  = to_fixed(5926);
  localparam longint unsigned K_HI_IR   = to_fixed(1185);

  typedef struct packed {
    logic                adjust;
    logic [CODE_W-1:0]   gain;
    logic [CODE_W-1:0]   itime;
    logic [LUX_W-1:0]    lux;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    vis;
    logic [CNT_W-1:0]    ir;
  } lux_result_t;

  lux_result_t expected_q[$];

  logic                auto_en;
  logic [CODE_W-1:0]   start_gain_r;
  logic [CODE_W-1:0]   start_time_r;
  logic [GLASS_W-1:0]  glass_r;
  logic [CODE_W-1:0]   gain_now;
  logic [CODE_W-1:0]   time_now;

  // a code off the ladder, or at its end, stays where it is
  function automatic logic [CODE_W-1:0] climb(input logic [23:0] rungs, input int n,
                                              input logic [CODE_W-1:0] code, input logic up);
    logic [CODE_W-1:0] nxt;
    nxt = code;
    for (int i = 0; i < n; i++) begin
      if (rungs[3*i +: 3] == code) begin
        if (up && i + 1 < n)
          nxt = rungs[3*(i+1) +: 3];
        else if (!up && i > 0)
          nxt = rungs[3*(i-1) +: 3];
      end
    end
    return nxt;
  endfunction

  function automatic lux_result_t predict_sample(input logic nc, input logic [CNT_W-1:0] vis,
                                                 input logic [CNT_W-1:0] ir);
    lux_result_t r;
    logic [CODE_W-1:0] g_next, t_next;
    logic go_up, in_band;
    logic [6:0] gmul;
    logic [8:0] ms;
    longint unsigned tot, ir100, a, b, sum, num, den, q;
    r = '0;
    r.vis = vis;
    r.ir = ir;
    r.status = ST_OK;
    if (nc) begin
      gain_now = start_gain_r;
      time_now = start_time_r;
    end
    go_up = (vis <= LOW_LIMIT);
    in_band = !go_up && (vis < HIGH_LIMIT);
    if (auto_en && !in_band) begin
      g_next = climb(24'(GAIN_RUNGS), 6, gain_now, go_up);
      t_next = climb(TIME_RUNGS, 8, time_now, go_up);
      // gain moves first, time only once gain cannot
      if (g_next != gain_now) begin
        gain_now = g_next;
        r.adjust = 1'b1;
      end else if (t_next != time_now) begin
        time_now = t_next;
        r.adjust = 1'b1;
      end
    end
    r.gain = gain_now;
    r.itime = time_now;
    if (r.adjust)
      return r;
    gmul = GAIN_FACTORS[gain_now*7 +: 7];
    ms = PERIOD_MS[time_now*9 +: 9];
    tot = 64'(vis) + 64'(ir);
    ir100 = 64'(ir) * 64'd100;
    sum = 0;
    if (vis == FULL_SCALE || ir == FULL_SCALE) begin
      r.status = ST_SAT;
    end else if (vis == 0 && ir == 0) begin
      r.status = ST_DARK;
    end else if (ir100 >= 64'd85 * tot) begin
      r.status = ST_RATIO;
    end else if (gmul == 0) begin
      r.status = ST_ZGAIN;
    end else begin
      // ratio boundaries by cross multiplication, no division
      if (ir100 < 64'd45 * tot) begin
        sum = K_LO_VIS * vis + K_LO_IR * ir;
      end else if (ir100 < 64'd64 * tot) begin
        a = K_MID_VIS * vis;
        b = K_MID_IR * ir;
        sum = (a > b) ? a - b : 64'd0;
      end else begin
        sum = K_HI_VIS * vis + K_HI_IR * ir;
      end
      num = sum * 64'(glass_r) * 64'd100;
      den = (64'(gmul) * 64'(ms)) << (COEF_FRAC + GLASS_FRAC - LUX_FRAC);
      q = (num + den / 2) / den;
      r.lux = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lux_result_t got, want;
    if (!rst_n) begin
      auto_en = 1'b0;
      start_gain_r = '0;
      start_time_r = '0;
      glass_r = GLASS_RESET;
      gain_now = '0;
      time_now = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AUTO:       auto_en = cfg_wdata[0];
          CFG_START_GAIN: start_gain_r = cfg_wdata[CODE_W-1:0];
          CFG_START_TIME: start_time_r = cfg_wdata[CODE_W-1:0];
          CFG_GLASS:      glass_r = cfg_wdata[GLASS_W-1:0];
        endcase
      end
      if (out_valid && !out_stall) begin
        got.adjust = out_adjust;
        got.gain = out_gain_code;
        got.itime = out_time_code;
        got.lux = out_lux_value;
        got.status = out_status;
        got.vis = out_visible_out;
        got.ir = out_infrared_out;
        if (expected_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with no request outstanding: vis=%h ir=%h",
                     $time, got.vis, got.ir);
          errors++;
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (want.adjust)
            n_adjust++;
          if (want.lux != 0)
            n_lux++;
          if (got !== want) begin
            if (errors < 10)
              $display({"%0t: mismatch expected adj=%0d gain=%0d time=%0d lux=%h st=%0d ",
                        "vis=%h ir=%h got adj=%0d gain=%0d time=%0d lux=%h st=%0d ",
                        "vis=%h ir=%h"}, $time,
                       want.adjust, want.gain, want.itime, want.lux, want.status,
                       want.vis, want.ir, got.adjust, got.gain, got.itime, got.lux,
                       got.status, got.vis, got.ir);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_sample(in_new_collection, in_visible_count,
                                            in_infrared_count));
    end
    pending = expected_q.size();
  end

endmodule

### verif/tb_ambient_light_autorange_lux.sv
`timescale 1ns / 100ps
module tb_ambient_light_autorange_lux;
  import alux_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 165;

  typedef enum {DIM, BRIGHT, MIDDLE, ANY} light_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_new_collection;
  logic [CNT_W-1:0]     in_visible_count;
  logic [CNT_W-1:0]     in_infrared_count;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_adjust;
  logic [CODE_W-1:0]    out_gain_code;
  logic [CODE_W-1:0]    out_time_code;
  logic [LUX_W-1:0]     out_lux_value;
  logic [STATUS_W-1:0]  out_status;
  logic [CNT_W-1:0]     out_visible_out;
  logic [CNT_W-1:0]     out_infrared_out;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  int errors, pending, n_checked, n_adjust, n_lux;
  int send_idle_pct, recv_idle_pct;
  int sent;
  int cycles;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_seq;

  ambient_light_autorange_lux dut (.*);
  alux_checker lux_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off counted here
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_sample(input logic nc, input logic [CNT_W-1:0] vis,
                             input logic [CNT_W-1:0] ir);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_new_collection <= nc;
    in_visible_count <= vis;
    in_infrared_count <= ir;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sent++;
  endtask

  task automatic wait_results_in();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic auto_on, input logic [CODE_W-1:0] gain0,
                              input logic [CODE_W-1:0] time0, input logic [GLASS_W-1:0] glass);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AUTO;
    cfg_wdata <= CFG_DAT_W'(auto_on);
    @(posedge clk);
    cfg_index <= CFG_START_GAIN;
    cfg_wdata <= CFG_DAT_W'(gain0);
    @(posedge clk);
    cfg_index <= CFG_START_TIME;
    cfg_wdata <= CFG_DAT_W'(time0);
    @(posedge clk);
    cfg_index <= CFG_GLASS;
    cfg_wdata <= glass;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void pick_light(input light_kind_t kind, output logic [CNT_W-1:0] vis,
                                     output logic [CNT_W-1:0] ir);
    int roll;
    longint unsigned scaled;
    case (kind)
      DIM:     vis = ($urandom_range(3) == 0) ? LOW_LIMIT : CNT_W'($urandom_range(2000));
      BRIGHT:  vis = ($urandom_range(3) == 0) ? HIGH_LIMIT
                                              : CNT_W'($urandom_range(65535, 50000));
      MIDDLE:  vis = CNT_W'($urandom_range(49999, 2001));
      default: begin
        roll = $urandom_range(7);
        vis = (roll == 0) ? FULL_SCALE : (roll == 1) ? '0 : CNT_W'($urandom);
      end
    endcase
    roll = $urandom_range(99);
    if (roll < 10) begin
      ir = CNT_W'($urandom);
    end else if (roll < 14) begin
      ir = FULL_SCALE;
    end else if (roll < 17) begin
      ir = '0;
    end else begin
      // infrared as a share of visible, spanning every ratio region
      scaled = 64'(vis) * 64'($urandom_range(600)) / 64'd100;
      ir = (scaled > 64'hFFFF) ? FULL_SCALE : scaled[CNT_W-1:0];
    end
  endfunction

  // mostly whole collections with a light trend, so the ladders get climbed
  task automatic run_phase(input int quota);
    int done_cnt, len;
    light_kind_t trend;
    logic [CNT_W-1:0] v, r;
    done_cnt = 0;
    while (done_cnt < quota) begin
      if ($urandom_range(99) < 78) begin
        len = $urandom_range(20, 1);
        trend = light_kind_t'($urandom_range(2));
        for (int i = 0; i < len; i++) begin
          pick_light(($urandom_range(4) == 0) ? light_kind_t'($urandom_range(3)) : trend,
                     v, r);
          send_sample(i == 0, v, r);
        end
        done_cnt += len;
      end else begin
        pick_light(ANY, v, r);
        send_sample(1'($urandom_range(1)), v, r);
        done_cnt++;
      end
    end
  endtask

  initial begin
    logic [CODE_W-1:0] g0, t0;
    logic [GLASS_W-1:0] glass;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_new_collection <= 1'b0;
    in_visible_count <= '0;
    in_infrared_count <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_AUTO;
    cfg_wdata <= '0;
    send_idle_pct <= 24;
    recv_idle_pct <= 79;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: manual range, lowest gain, 100 ms, clear glass
    send_sample(1'b1, 16'd0, 16'd0);
    send_sample(1'b0, FULL_SCALE, 16'd0);
    send_sample(1'b0, 16'd100, FULL_SCALE);
    send_sample(1'b0, FULL_SCALE, FULL_SCALE);
    send_sample(1'b0, 16'd1000, 16'd100);
    send_sample(1'b0, 16'd55, 16'd45);
    send_sample(1'b0, 16'd36, 16'd64);
    send_sample(1'b0, 16'd15, 16'd85);
    send_sample(1'b0, 16'd0, 16'd1);
    send_sample(1'b0, 16'd65534, 16'd0);
    send_sample(1'b0, 16'd30000, 16'd40000);
    send_sample(1'b0, 16'd1, 16'd0);
    wait_results_in();

    // gain code with no multiplier, and the priority of the other statuses over it
    program_regs(1'b0, 3'd4, 3'd5, 12'd4095);
    send_sample(1'b1, 16'd30000, 16'd1000);
    send_sample(1'b0, 16'd0, 16'd0);
    send_sample(1'b0, 16'd15, 16'd85);
    wait_results_in();

    // off-ladder gain: time steps instead, limits exactly on the boundaries
    program_regs(1'b1, 3'd4, 3'd0, 12'd128);
    send_sample(1'b1, LOW_LIMIT, 16'd100);
    send_sample(1'b0, 16'd2001, 16'd100);
    send_sample(1'b0, HIGH_LIMIT, 16'd0);
    send_sample(1'b0, 16'd49999, 16'd10);
    wait_results_in();

    // most sensitive end: no room to go up; stepping down wins over saturation
    program_regs(1'b1, 3'd7, 3'd3, 12'd256);
    send_sample(1'b1, 16'd500, 16'd50);
    send_sample(1'b0, FULL_SCALE, 16'd0);
    wait_results_in();

    // least sensitive end with zero glass factor
    program_regs(1'b1, 3'd0, 3'd1, 12'd0);
    send_sample(1'b1, 16'd60000, 16'd60000);
    send_sample(1'b0, 16'd0, 16'd0);
    send_sample(1'b1, 16'd100, 16'd10);
    send_sample(1'b0, 16'd3000, 16'd3000);
    wait_results_in();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_idle_pct <= 79;
        recv_idle_pct <= 24;
      end else if (p == 2 * PHASES / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      g0 = (p == 0) ? 3'd0 : (p == 1) ? 3'd7 : (p == 2) ? 3'd4 : CODE_W'($urandom);
      t0 = (p == 0) ? 3'd1 : (p == 1) ? 3'd3 : CODE_W'($urandom);
      glass = (p % 3 == 0) ? 12'd4095 : (p == 4) ? 12'd0 : (p == 7) ? GLASS_RESET
                                                                     : GLASS_W'($urandom);
      program_regs(p % 4 != 3, g0, t0, glass);
      if (p == 1 || p == 9)
        hold_seq <= hold_seq + 1;
      if (p == 6) begin
        run_phase(PHASE_ITEMS / 2);
        // let every result come home before carrying on
        wait_results_in();
        run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_phase(PHASE_ITEMS);
      end
      wait_results_in();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests over %0d register settings, sender and receiver idling in turn",
             sent, PHASES + 5);
    $display("%0d results checked, %0d range steps, %0d non-zero lux values, %0d mismatches",
             n_checked, n_adjust, n_lux, errors);
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
